// ===== rtl/core/fss_pkg.sv =====
// fractional slice shift: shared widths, register indexes, reset values and control types
`timescale 1ns / 1ps
package fss_pkg;

  localparam int IDX_W      = 10;
  localparam int SMP_W      = 16;
  localparam int FRAC_W     = 8;
  localparam int SHIFT_W    = 19;
  localparam int LEN_W      = 11;
  localparam int MAX_LEN    = 1024;
  localparam int TDATA_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  // signed working widths
  localparam int POS_W  = IDX_W + FRAC_W + 3;   // i*one - d
  localparam int KW     = POS_W - FRAC_W;        // integer part of a position
  localparam int PROD_W = SMP_W + FRAC_W + 2;
  localparam int ACC_W  = PROD_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_SLICE_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL      = 3'd4;

  localparam logic [LEN_W-1:0]   RST_SLICE_LEN = 11'd1024;
  localparam logic [IDX_W-1:0]   RST_SEL_LOW   = 10'd0;
  localparam logic [IDX_W-1:0]   RST_SEL_HIGH  = 10'd1023;
  localparam logic [SHIFT_W-1:0] RST_SHIFT     = 19'd0;
  localparam logic [SMP_W-1:0]   RST_FILL      = 16'hA000;

  typedef struct packed {
    logic load_wr;   // write an incoming sample word into the store
    logic capture;   // latch a read word
    logic calc_en;   // position and region bounds
    logic sel_en;    // neighbor selection and store addresses
    logic mem_en;    // store read
    logic mul_en;    // blend products
    logic out_load;  // final sum into the output register
  } fss_cmd_t;

endpackage

// ===== rtl/core/fss_ctrl.sv =====
// fractional slice shift: controller sequencing one read word through the datapath
`timescale 1ns / 1ps
module fss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_mode,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  output fss_pkg::fss_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_SEL,
    S_MEM,
    S_MUL,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // nothing is taken while reset is held
  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load_wr  = in_tready && in_tvalid && !in_mode;
    cmd.capture  = in_tready && in_tvalid && in_mode;
    cmd.calc_en  = (state_r == S_CALC);
    cmd.sel_en   = (state_r == S_SEL);
    cmd.mem_en   = (state_r == S_MEM);
    cmd.mul_en   = (state_r == S_MUL);
    // the output register frees up in the same cycle its word is taken
    cmd.out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.capture) state_nxt = S_CALC;
      S_CALC: state_nxt = S_SEL;
      S_SEL:  state_nxt = S_MEM;
      S_MEM:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_OUT;
      S_OUT:  if (cmd.out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/fss_dp.sv =====
// fractional slice shift: config registers, sample store and interpolation datapath
`timescale 1ns / 1ps
module fss_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fss_pkg::fss_cmd_t                  cmd,
  input  logic                               cfg_wr_en,
  input  logic [fss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [fss_pkg::IDX_W-1:0]          in_index,
  input  logic signed [fss_pkg::SMP_W-1:0]   in_value,
  output logic [fss_pkg::IDX_W-1:0]          res_index,
  output logic signed [fss_pkg::SMP_W-1:0]   res_value
);

  localparam int IDX_W   = fss_pkg::IDX_W;
  localparam int SMP_W   = fss_pkg::SMP_W;
  localparam int FRAC_W  = fss_pkg::FRAC_W;
  localparam int SHIFT_W = fss_pkg::SHIFT_W;
  localparam int LEN_W   = fss_pkg::LEN_W;
  localparam int POS_W   = fss_pkg::POS_W;
  localparam int KW      = fss_pkg::KW;
  localparam int PROD_W  = fss_pkg::PROD_W;
  localparam int ACC_W   = fss_pkg::ACC_W;
  localparam int Q_W     = ACC_W - FRAC_W;

  // config registers
  logic [LEN_W-1:0]          slice_len_r;
  logic [IDX_W-1:0]          sel_low_r;
  logic [IDX_W-1:0]          sel_high_r;
  logic signed [SHIFT_W-1:0] shift_r;
  logic signed [SMP_W-1:0]   fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_len_r <= fss_pkg::RST_SLICE_LEN;
      sel_low_r   <= fss_pkg::RST_SEL_LOW;
      sel_high_r  <= fss_pkg::RST_SEL_HIGH;
      shift_r     <= fss_pkg::RST_SHIFT;
      fill_r      <= fss_pkg::RST_FILL;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fss_pkg::REG_SLICE_LEN: slice_len_r <= cfg_wdata[LEN_W-1:0];
        fss_pkg::REG_SEL_LOW:   sel_low_r   <= cfg_wdata[IDX_W-1:0];
        fss_pkg::REG_SEL_HIGH:  sel_high_r  <= cfg_wdata[IDX_W-1:0];
        fss_pkg::REG_SHIFT:     shift_r     <= cfg_wdata[SHIFT_W-1:0];
        fss_pkg::REG_FILL:      fill_r      <= cfg_wdata[SMP_W-1:0];
        default: ;
      endcase
    end
  end

  // sample store, one write port and two read ports
  logic [SMP_W-1:0] mem [fss_pkg::MAX_LEN];
  logic [IDX_W-1:0] addr_a_r;
  logic [IDX_W-1:0] addr_b_r;
  logic signed [SMP_W-1:0] rd_a_r;
  logic signed [SMP_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem[in_index] <= in_value;
    end
    if (cmd.mem_en) begin
      rd_a_r <= mem[addr_a_r];
      rd_b_r <= mem[addr_b_r];
    end
  end

  // read word capture
  logic [IDX_W-1:0] idx_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r <= in_index;
    end
  end

  // calc stage: position s = i - d and region bounds shifted by floor(d)
  logic signed [KW-1:0]    shift_int;
  logic signed [KW-1:0]    low_s;
  logic signed [KW-1:0]    high_s;
  logic signed [KW-1:0]    idx_s;
  logic signed [POS_W-1:0] pos;
  logic signed [POS_W-1:0] pos_r;
  logic signed [KW-1:0]    lo_bnd_r;
  logic signed [KW-1:0]    hi_bnd_r;
  logic                    in_len_r;
  logic                    in_sel_r;

  assign shift_int = KW'(shift_r >>> FRAC_W);
  assign low_s     = $signed(KW'(sel_low_r));
  assign high_s    = $signed(KW'(sel_high_r));
  assign idx_s     = $signed(KW'(idx_r));
  assign pos       = $signed({(POS_W - IDX_W - FRAC_W)'(0), idx_r, FRAC_W'(0)})
                   - POS_W'(shift_r);

  always_ff @(posedge clk) begin
    if (cmd.calc_en) begin
      pos_r    <= pos;
      lo_bnd_r <= low_s + shift_int;
      hi_bnd_r <= high_s + shift_int + KW'(2);
      in_len_r <= LEN_W'(idx_r) < slice_len_r;
      in_sel_r <= (idx_r >= sel_low_r) && (idx_r <= sel_high_r);
    end
  end

  // select stage: which neighbors come from the store
  logic signed [KW-1:0]  k;
  logic signed [KW-1:0]  k1;
  logic [FRAC_W-1:0]     frac;
  logic                  in0;
  logic                  in1;
  logic                  region;
  logic                  interp;
  logic                  use0_r;
  logic                  use1_r;
  logic [FRAC_W-1:0]     frac_r;

  assign k      = pos_r[POS_W-1:FRAC_W];
  assign k1     = k + KW'(1);
  assign frac   = pos_r[FRAC_W-1:0];
  assign in0    = (k >= low_s) && (k <= high_s);
  assign in1    = (k1 >= low_s) && (k1 <= high_s);
  assign region = (idx_s >= lo_bnd_r) && (idx_s < hi_bnd_r) && in_len_r;
  assign interp = region && (in0 || in1);

  always_ff @(posedge clk) begin
    if (cmd.sel_en) begin
      // outside the blend the word is store[i] or fill, passed with zero fraction
      addr_a_r <= interp ? k[IDX_W-1:0] : idx_r;
      addr_b_r <= k1[IDX_W-1:0];
      use0_r   <= interp ? in0 : !in_sel_r;
      use1_r   <= interp && in1;
      frac_r   <= interp ? frac : FRAC_W'(0);
    end
  end

  // multiply stage
  logic signed [SMP_W-1:0]  v0;
  logic signed [SMP_W-1:0]  v1;
  logic [FRAC_W:0]          w0;
  logic signed [PROD_W-1:0] p0_r;
  logic signed [PROD_W-1:0] p1_r;

  assign v0 = use0_r ? rd_a_r : fill_r;
  assign v1 = use1_r ? rd_b_r : fill_r;
  assign w0 = {1'b1, FRAC_W'(0)} - {1'b0, frac_r};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p0_r <= PROD_W'(v0) * PROD_W'($signed({1'b0, w0}));
      p1_r <= PROD_W'(v1) * PROD_W'($signed({2'b0, frac_r}));
    end
  end

  // sum stage: round half up, then saturate
  logic signed [ACC_W-1:0] acc;
  logic signed [Q_W-1:0]   q;
  logic signed [SMP_W-1:0] q_sat;
  localparam logic signed [Q_W-1:0] QMAX = Q_W'((1 << (SMP_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] QMIN = -QMAX - Q_W'(1);

  assign acc = ACC_W'(p0_r) + ACC_W'(p1_r) + ACC_W'(1 << (FRAC_W - 1));
  assign q   = acc[ACC_W-1:FRAC_W];

  always_comb begin
    if (q > QMAX) begin
      q_sat = QMAX[SMP_W-1:0];
    end else if (q < QMIN) begin
      q_sat = QMIN[SMP_W-1:0];
    end else begin
      q_sat = q[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_index <= idx_r;
      res_value <= q_sat;
    end
  end

endmodule

// ===== rtl/core/fractional_slice_shift_top.sv =====
// fractional slice shift: top level with stream ports and config write port
// load words are accepted back to back while no read word is in flight
// the controller walks each read word through calc, select, store read, multiply and sum steps
// and takes no new word until the last one has been loaded into the output register
// the result sits in an output register, so a new word is taken while it waits
// reset restores the config defaults; the sample store is not cleared and reads undefined
`timescale 1ns / 1ps
module fractional_slice_shift_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fss_pkg::TDATA_W-1:0]         in_tdata,   // index[9:0], value[25:10]
  input  logic                                in_tuser,   // mode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fss_pkg::TDATA_W-1:0]         out_tdata,  // out_index[9:0], out_value[25:10]
  input  logic                                cfg_wr_en,
  input  logic [fss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fss_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int IDX_W = fss_pkg::IDX_W;
  localparam int SMP_W = fss_pkg::SMP_W;

  fss_pkg::fss_cmd_t       cmd;
  logic [IDX_W-1:0]        res_index;
  logic signed [SMP_W-1:0] res_value;

  fss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  fss_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_index  (in_tdata[IDX_W-1:0]),
    .in_value  (in_tdata[IDX_W+SMP_W-1:IDX_W]),
    .res_index (res_index),
    .res_value (res_value)
  );

  assign out_tdata = {(fss_pkg::TDATA_W - IDX_W - SMP_W)'(0), res_value, res_index};

endmodule

// ===== tb/fss_shift_checker.sv =====
// result checker for the fractional slice shift: mirrors registers and store, predicts each read
`timescale 1ns / 1ps
module fss_shift_checker #(
  parameter logic MODE_READ = 1'b1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [fss_pkg::TDATA_W-1:0]         in_tdata,   // index[9:0], value[25:10]
  input  logic                                in_tuser,   // mode
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [fss_pkg::TDATA_W-1:0]         out_tdata,  // out_index[9:0], out_value[25:10]
  input  logic                                cfg_wr_en,
  input  logic [fss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fss_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output int                                  mismatches,
  output int                                  pending,
  output int                                  checked
);
  import fss_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [SMP_W-1:0] value;
  } shift_result_t;

  logic [LEN_W-1:0]          slice_len_r;
  logic [IDX_W-1:0]          sel_lo_r;
  logic [IDX_W-1:0]          sel_hi_r;
  logic signed [SHIFT_W-1:0] shift_r;
  logic signed [SMP_W-1:0]   fill_r;
  logic signed [SMP_W-1:0]   sample_mem [MAX_LEN];
  shift_result_t             shifted_q [$];

  initial begin
    mismatches = 0;
    checked    = 0;
    pending    = 0;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    // keep the log short when everything goes wrong
    if (mismatches <= 100) begin
      $display("%0t mismatch: %s, got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  function automatic longint stored_at(longint k);
    if (k < 0 || k >= MAX_LEN) return 0;
    return longint'(sample_mem[k]);
  endfunction

  function automatic logic [SMP_W-1:0] shifted_sample(longint i);
    longint one, d, whole, len, lo, hi, fill, r_lo, r_hi;
    longint s, k, f, v0, v1, acc, res, top_val;
    bit in_sel, in0, in1;
    one     = longint'(1) << FRAC_W;
    top_val = (longint'(1) << (SMP_W - 1)) - 1;
    d       = longint'(shift_r);
    whole   = d >>> FRAC_W;
    len     = (slice_len_r > MAX_LEN) ? MAX_LEN : longint'(slice_len_r);
    lo      = sel_lo_r;
    hi      = sel_hi_r;
    fill    = longint'(fill_r);
    r_lo    = lo + whole;
    if (r_lo < 0) r_lo = 0;
    r_hi = hi + whole + 2;
    if (r_hi > len) r_hi = len;
    in_sel = (i >= lo) && (i <= hi);
    // vacated places read fill, unselected places keep their sample
    res = in_sel ? fill : stored_at(i);
    if (i >= r_lo && i < r_hi) begin
      s   = i * one - d;
      k   = s >>> FRAC_W;
      f   = s - k * one;
      in0 = (k >= lo) && (k <= hi);
      in1 = (k + 1 >= lo) && (k + 1 <= hi);
      if (in0 || in1) begin
        v0  = in0 ? stored_at(k) : fill;
        v1  = in1 ? stored_at(k + 1) : fill;
        // round half up
        acc = v0 * (one - f) + v1 * f + (one >> 1);
        res = acc >>> FRAC_W;
        if (res > top_val) res = top_val;
        if (res < -top_val - 1) res = -top_val - 1;
      end
    end
    return res[SMP_W-1:0];
  endfunction

  always @(posedge clk) begin
    shift_result_t want;
    logic [IDX_W-1:0] idx;
    if (!rst_n) begin
      slice_len_r = RST_SLICE_LEN;
      sel_lo_r    = RST_SEL_LOW;
      sel_hi_r    = RST_SEL_HIGH;
      shift_r     = RST_SHIFT;
      fill_r      = RST_FILL;
      shifted_q.delete();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (shifted_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding, index",
                          out_tdata[IDX_W-1:0], -1);
        end else begin
          want = shifted_q.pop_front();
          checked++;
          if (out_tdata[IDX_W-1:0] !== want.idx) begin
            report_mismatch("out_index", out_tdata[IDX_W-1:0], want.idx);
          end
          if (out_tdata[IDX_W +: SMP_W] !== want.value) begin
            report_mismatch("out_value", $signed(out_tdata[IDX_W +: SMP_W]),
                            $signed(want.value));
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SLICE_LEN: slice_len_r = cfg_wdata[LEN_W-1:0];
          REG_SEL_LOW:   sel_lo_r    = cfg_wdata[IDX_W-1:0];
          REG_SEL_HIGH:  sel_hi_r    = cfg_wdata[IDX_W-1:0];
          REG_SHIFT:     shift_r     = cfg_wdata[SHIFT_W-1:0];
          REG_FILL:      fill_r      = cfg_wdata[SMP_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        idx = in_tdata[IDX_W-1:0];
        if (in_tuser == MODE_READ) begin
          want.idx   = idx;
          want.value = shifted_sample(idx);
          shifted_q  = {shifted_q, want};
        end else begin
          sample_mem[idx] = in_tdata[IDX_W +: SMP_W];
        end
      end
      pending <= shifted_q.size();
    end
  end

endmodule

// ===== tb/tb_fractional_slice_shift_top.sv =====
// testbench top for the fractional slice shift: stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module tb_fractional_slice_shift_top;
  import fss_pkg::*;

  localparam logic MODE_LOAD      = 1'b0;
  localparam logic MODE_READ      = 1'b1;
  localparam int   DRAIN_CYCLES   = 8;
  localparam int   RANDOM_PHASES  = 4;
  localparam int   WORDS_PER_SET  = 50;
  localparam int   LIMIT_NS       = 5_000_000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata   = '0;
  logic                  in_tuser   = MODE_LOAD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int mismatches;
  int pending;
  int checked;
  bit quiet   = 1'b0;
  int rx_wait = 0;
  int loads_sent = 0;
  int reads_sent = 0;
  int settings   = 0;
  int cur_lo, cur_hi, cur_shift;

  fractional_slice_shift_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  fss_shift_checker #(.MODE_READ(MODE_READ)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: stall a random number of cycles after each word taken
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      rx_wait = quiet ? 0 : $urandom_range(0, 7);
      out_tready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      out_tready <= (rx_wait == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_word(logic mode, logic [IDX_W-1:0] idx, logic [SMP_W-1:0] val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{(TDATA_W - IDX_W - SMP_W){1'b0}}, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode == MODE_READ) reads_sent++;
    else loads_sent++;
  endtask

  // hold the input until every outstanding read has come back, then let the pipe settle
  task automatic wait_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_regs(int len, int lo, int hi, int shift, int fill, bit poke_unused);
    write_reg(REG_SLICE_LEN, CFG_DATA_W'(len));
    write_reg(REG_SEL_LOW, CFG_DATA_W'(lo));
    write_reg(REG_SEL_HIGH, CFG_DATA_W'(hi));
    write_reg(REG_SHIFT, CFG_DATA_W'(shift));
    write_reg(REG_FILL, CFG_DATA_W'(fill));
    // indexes past the fill register must be dropped
    if (poke_unused) begin
      write_reg(CFG_IDX_W'(REG_FILL + $urandom_range(1, 3)), CFG_DATA_W'($urandom));
    end
    cfg_wr_en <= 1'b0;
    cur_lo    = lo;
    cur_hi    = hi;
    cur_shift = shift;
    settings++;
  endtask

  // output index around the shifted selection, where interpolation happens
  function automatic logic [IDX_W-1:0] read_near();
    int span, i;
    span = (cur_hi >= cur_lo) ? cur_hi - cur_lo + 6 : 6;
    i = cur_lo + (cur_shift >>> FRAC_W) - 2 + $urandom_range(0, span);
    if (i < 0) i = 0;
    if (i > MAX_LEN - 1) i = MAX_LEN - 1;
    return i[IDX_W-1:0];
  endfunction

  initial begin
    int len, lo, hi, shift, fill, raw;
    logic [SMP_W-1:0] smp;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole store first so no read ever touches an unwritten entry
    quiet = 1'b1;
    for (int k = 0; k < MAX_LEN; k++) begin
      case (k)
        0, 1022: smp = 16'h7FFF;
        1, 1023: smp = 16'h8000;
        14:      smp = 16'h0001;
        default: smp = SMP_W'($urandom);
      endcase
      send_word(MODE_LOAD, IDX_W'(k), smp);
    end
    quiet = 1'b0;

    // reset settings, no shift: reads return the stored samples
    send_word(MODE_READ, 10'd0, 16'h0000);
    send_word(MODE_READ, 10'd1023, 16'hFFFF);
    send_word(MODE_READ, 10'd1, 16'h0000);
    wait_results();

    // one-and-a-half-sample shift into a narrow selection: ties, vacated edge, outside neighbors
    set_regs(1024, 10, 20, 384, 32767, 1'b1);
    send_word(MODE_LOAD, 10'd15, 16'h8000);
    send_word(MODE_LOAD, 10'd14, 16'h0001);
    send_word(MODE_READ, 10'd10, 16'h0000);
    send_word(MODE_READ, 10'd11, 16'h0000);
    send_word(MODE_READ, 10'd12, 16'h0000);
    send_word(MODE_READ, 10'd16, 16'h0000);
    send_word(MODE_READ, 10'd21, 16'h0000);
    send_word(MODE_READ, 10'd22, 16'h0000);
    send_word(MODE_READ, 10'd23, 16'h0000);
    send_word(MODE_READ, 10'd5, 16'h0000);
    wait_results();

    // negative quarter-sample shift at the top of the store
    set_regs(1024, 1020, 1023, -64, -32768, 1'b1);
    send_word(MODE_READ, 10'd1023, 16'h0000);
    send_word(MODE_READ, 10'd1022, 16'h0000);
    wait_results();

    // empty selection
    set_regs(1024, 600, 500, 256, 0, 1'b0);
    send_word(MODE_READ, 10'd550, 16'h0000);
    wait_results();

    // zero slice length
    set_regs(0, 0, 1023, 0, 1000, 1'b0);
    send_word(MODE_READ, 10'd7, 16'h0000);
    wait_results();

    // length beyond the store with the most negative shift
    set_regs(2047, 0, 1023, -262144, 0, 1'b0);
    send_word(MODE_READ, 10'd0, 16'h0000);
    send_word(MODE_READ, 10'd1023, 16'h0000);
    wait_results();

    // short slice, selection running past its end, neighbor at len read from store
    set_regs(8, 4, 20, -640, 77, 1'b0);
    send_word(MODE_READ, 10'd6, 16'h0000);
    send_word(MODE_READ, 10'd9, 16'h0000);
    wait_results();

    // largest positive shift, one-sample slice
    set_regs(1024, 0, 1023, 262143, -1, 1'b0);
    send_word(MODE_READ, 10'd1023, 16'h0000);
    wait_results();
    set_regs(1, 0, 1023, 0, 5, 1'b0);
    send_word(MODE_READ, 10'd0, 16'h0000);
    send_word(MODE_READ, 10'd1, 16'h0000);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_results();
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) len = $urandom_range(0, 2047);
      else if ($urandom_range(0, 1) == 0) len = MAX_LEN;
      else len = $urandom_range(1, MAX_LEN);
      lo = $urandom_range(0, MAX_LEN - 1);
      if ($urandom_range(0, 7) == 0) begin
        hi = $urandom_range(0, MAX_LEN - 1);
      end else begin
        hi = lo + $urandom_range(0, 200);
        if (hi > MAX_LEN - 1) hi = MAX_LEN - 1;
      end
      if ($urandom_range(0, 3) == 0) begin
        raw   = $urandom_range(0, (1 << SHIFT_W) - 1);
        shift = (raw >= (1 << (SHIFT_W - 1))) ? raw - (1 << SHIFT_W) : raw;
      end else begin
        shift = $urandom_range(0, 4096) - 2048;
      end
      fill = $urandom_range(0, 65535) - 32768;
      set_regs(len, lo, hi, shift, fill, $urandom_range(0, 3) == 0);
      for (int n = 0; n < WORDS_PER_SET; n++) begin
        if (n == WORDS_PER_SET / 2 && p % 3 == 0) wait_results();
        if ($urandom_range(0, 3) == 0) begin
          send_word(MODE_LOAD, IDX_W'($urandom), SMP_W'($urandom));
        end else if ($urandom_range(0, 2) == 0) begin
          send_word(MODE_READ, IDX_W'($urandom), SMP_W'($urandom));
        end else begin
          send_word(MODE_READ, read_near(), SMP_W'($urandom));
        end
      end
    end

    wait_results();
    $display("covered %0d sample loads and %0d shifted reads over %0d register settings",
             loads_sent, reads_sent, settings);
    $display("%0d result words compared, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_fractional_slice_shift_top OK");
    end else begin
      $display("tb_fractional_slice_shift_top NOT OK");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("run stopped: results did not arrive in time");
    $display("tb_fractional_slice_shift_top NOT OK");
    $finish;
  end

endmodule
